[rtl/pfcx_pkg.sv]
// pfcx_pkg: shared types and constants for the polyline first crossing block.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package pfcx_pkg;

    localparam int DEF_MAX_PATH_POINTS  = 256;
    localparam int DEF_MAX_CURVE_POINTS = 256;
    localparam int DEF_FRAC_BITS        = 16;

    localparam int QUEUE_DEPTH = 4;

    localparam int COORD_W = 32;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int MAG_W   = COORD_W;
    localparam int PROD_W  = 2 * MAG_W;
    localparam int DET_W   = PROD_W + 2;
    localparam int NUM_W   = DET_W + MAG_W - 1;
    localparam int QUO_W   = MAG_W;

    typedef enum logic [1:0] {
        OP_PATH    = 2'd0,
        OP_CURVE   = 2'd1,
        OP_COMPUTE = 2'd2
    } t_op;

    typedef struct packed {
        t_op                        op;
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
    } t_word;

endpackage

`default_nettype wire

[rtl/polyline_first_crossing_x.sv]
// polyline_first_crossing_x: top level, queue front end and search back end.
// Depends on pfcx_pkg, pfcx_front, pfcx_back (which holds pfcx_div).
//
//  channel   handshake        payload
//  command   start / busy     i_command, i_coord_x, i_coord_y
//  result    o_valid strobe   o_stop_x, o_found, o_overflow
//
// An append word is stored by the back end in its idle state; a four-word queue sits in front.
// A compute word loads the first pair of each path segment through S_LD_A, S_LD_B and
// S_LD_C, and each further curve segment up to the first hit through S_NXT_J and S_LD_J;
// every pair goes through the single shared 32x32 multiplier (six products per pair), and
// a proper crossing adds the offset product and the one-bit-per-cycle divider.
// busy is high only while the queue is full. Reset is synchronous and clears counts.
// The result is a one-cycle strobe; the receiver cannot stall it.
`default_nettype none

module polyline_first_crossing_x
    import pfcx_pkg::*;
#(
    parameter int MAX_PATH_POINTS  = DEF_MAX_PATH_POINTS,
    parameter int MAX_CURVE_POINTS = DEF_MAX_CURVE_POINTS,
    parameter int FRAC_BITS        = DEF_FRAC_BITS
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic [1:0]                 i_command,
    input  wire logic signed [COORD_W-1:0]  i_coord_x,
    input  wire logic signed [COORD_W-1:0]  i_coord_y,
    output logic                            o_valid,
    output logic signed [COORD_W-1:0]       o_stop_x,
    output logic                            o_found,
    output logic                            o_overflow
);

    logic   q_valid;
    t_word  q_word;
    logic   q_ready;

    pfcx_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_command (i_command),
        .i_coord_x (i_coord_x),
        .i_coord_y (i_coord_y),
        .o_valid   (q_valid),
        .o_word    (q_word),
        .i_ready   (q_ready)
    );

    pfcx_back #(
        .MAX_PATH_POINTS  (MAX_PATH_POINTS),
        .MAX_CURVE_POINTS (MAX_CURVE_POINTS),
        .FRAC_BITS        (FRAC_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (q_valid),
        .i_word     (q_word),
        .o_ready    (q_ready),
        .o_valid    (o_valid),
        .o_stop_x   (o_stop_x),
        .o_found    (o_found),
        .o_overflow (o_overflow)
    );

endmodule

`default_nettype wire

[rtl/pfcx_front.sv]
// pfcx_front: accepts command words, drops undefined codes and queues the rest.
// Depends on pfcx_pkg; feeds pfcx_back.
`default_nettype none

module pfcx_front
    import pfcx_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic [1:0]                 i_command,
    input  wire logic signed [COORD_W-1:0]  i_coord_x,
    input  wire logic signed [COORD_W-1:0]  i_coord_y,
    output logic                            o_valid,
    output t_word                           o_word,
    input  wire logic                       i_ready
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_word              r_q [QUEUE_DEPTH];
    logic [PW-1:0]      r_wr;
    logic [PW-1:0]      r_rd;
    logic [CW-1:0]      r_cnt;
    logic               accept;
    logic               keep;
    logic               push;
    logic               pop;
    t_op                op;

    always_comb begin
        keep = 1'b1;
        op   = OP_PATH;
        unique case (i_command)
            OP_PATH:    op = OP_PATH;
            OP_CURVE:   op = OP_CURVE;
            OP_COMPUTE: op = OP_COMPUTE;
            default:    keep = 1'b0;
        endcase
    end

    assign busy    = (r_cnt == CW'(QUEUE_DEPTH));
    assign accept  = start && !busy;
    assign push    = accept && keep;
    assign o_valid = (r_cnt != '0);
    assign pop     = o_valid && i_ready;
    assign o_word  = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= '{op: op, x: i_coord_x, y: i_coord_y};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_fill_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !pop && r_cnt == CW'(QUEUE_DEPTH - 1) |=> busy)
        else $error("queue filled without raising busy");
`endif

endmodule

`default_nettype wire

[rtl/pfcx_div.sv]
// pfcx_div: restoring divider, one quotient bit per cycle.
// Depends on pfcx_pkg; used by pfcx_back for the crossing offset.
`default_nettype none

module pfcx_div
    import pfcx_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [NUM_W-1:0]   i_num,
    input  wire logic [DET_W-1:0]   i_den,
    output logic                    o_done,
    output logic [QUO_W-1:0]        o_quo
);

    localparam int RW = DET_W + 1;
    localparam int KW = $clog2(QUO_W);

    logic [RW-1:0]      r_rem;
    logic [QUO_W-1:0]   r_low;
    logic [QUO_W-1:0]   r_quo;
    logic [KW-1:0]      r_k;
    logic               r_run;
    logic               r_done;
    logic [RW-1:0]      trial;
    logic               ge;

    assign trial  = {r_rem[RW-2:0], r_low[QUO_W-1]};
    assign ge     = (trial >= {1'b0, i_den});
    assign o_done = r_done;
    assign o_quo  = r_quo;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= RW'(i_num[NUM_W-1:QUO_W]);
            r_low <= i_num[QUO_W-1:0];
        end else if (r_run) begin
            r_rem <= ge ? trial - {1'b0, i_den} : trial;
            r_low <= {r_low[QUO_W-2:0], 1'b0};
            r_quo <= {r_quo[QUO_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_k    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_k   <= '0;
            end else if (r_run) begin
                r_k <= r_k + 1'b1;
                if (r_k == KW'(QUO_W - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_start_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> !o_done)
        else $error("quotient reported right after start");
`endif

endmodule

`default_nettype wire

[rtl/pfcx_back.sv]
// pfcx_back: point stores, segment pair search and result register.
// Depends on pfcx_pkg and pfcx_div; fed by pfcx_front.
`default_nettype none

module pfcx_back
    import pfcx_pkg::*;
#(
    parameter int MAX_PATH_POINTS  = DEF_MAX_PATH_POINTS,
    parameter int MAX_CURVE_POINTS = DEF_MAX_CURVE_POINTS,
    parameter int FRAC_BITS        = DEF_FRAC_BITS
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    input  wire t_word                  i_word,
    output logic                        o_ready,
    output logic                        o_valid,
    output logic signed [COORD_W-1:0]   o_stop_x,
    output logic                        o_found,
    output logic                        o_overflow
);

    localparam int PAW = $clog2(MAX_PATH_POINTS);
    localparam int PCW = $clog2(MAX_PATH_POINTS + 1);
    localparam int CAW = $clog2(MAX_CURVE_POINTS);
    localparam int CCW = $clog2(MAX_CURVE_POINTS + 1);
    localparam logic [COORD_W-1:0] ONE = COORD_W'(1) << FRAC_BITS;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_LD_A  = 12'b0000_0000_0010,
        S_LD_B  = 12'b0000_0000_0100,
        S_LD_C  = 12'b0000_0000_1000,
        S_NXT_J = 12'b0000_0001_0000,
        S_LD_J  = 12'b0000_0010_0000,
        S_DIF   = 12'b0000_0100_0000,
        S_MUL   = 12'b0000_1000_0000,
        S_EVAL  = 12'b0001_0000_0000,
        S_NUM   = 12'b0010_0000_0000,
        S_DIV   = 12'b0100_0000_0000,
        S_DONE  = 12'b1000_0000_0000
    } t_state;

    logic signed [COORD_W-1:0]  path_x  [MAX_PATH_POINTS];
    logic signed [COORD_W-1:0]  path_y  [MAX_PATH_POINTS];
    logic signed [COORD_W-1:0]  curve_x [MAX_CURVE_POINTS];
    logic signed [COORD_W-1:0]  curve_y [MAX_CURVE_POINTS];

    t_state                     r_state;
    logic [PCW-1:0]             r_pc;
    logic [CCW-1:0]             r_cc;
    logic                       r_drop;
    logic [PAW-1:0]             r_i;
    logic [CAW-1:0]             r_j;
    logic [2:0]                 r_k;
    logic signed [COORD_W-1:0]  r_px, r_py, r_cx, r_cy;
    logic signed [COORD_W-1:0]  r_x1, r_y1, r_x2, r_y2, r_x3, r_y3, r_x4, r_y4;
    logic [MAG_W-1:0]           r_ma, r_mb, r_mc, r_md, r_me, r_mf;
    logic                       r_sa, r_sb, r_sc, r_sd, r_se, r_sf;
    logic [PROD_W-1:0]          r_prod;
    logic                       r_psg;
    logic signed [DET_W-1:0]    r_p, r_d, r_q;
    logic [PROD_W-1:0]          r_pm;
    logic [DET_W-1:0]           r_dm;
    logic                       r_neg;
    logic [NUM_W-1:0]           r_num;
    logic                       r_div_start;
    logic signed [COORD_W-1:0]  r_stop;
    logic                       r_found;
    logic                       r_out_valid;
    logic signed [COORD_W-1:0]  r_out_stop;
    logic                       r_out_found;
    logic                       r_out_ovf;

    logic [PAW-1:0]             path_addr;
    logic [CAW-1:0]             curve_addr;
    logic                       take;
    logic                       we_path;
    logic                       we_curve;
    logic [MAG_W-1:0]           mul_a, mul_b;
    logic                       mul_s;
    logic signed [DET_W-1:0]    term;
    logic signed [DIFF_W-1:0]   da, db, dc, dd, de, df;
    logic [DET_W-1:0]           p_abs, d_abs;
    logic                       d_zero, p_zero, q_zero, proper, collinear_hit;
    logic signed [COORD_W-1:0]  col_x;
    logic                       more_j, more_i;
    logic                       div_done;
    logic [QUO_W-1:0]           div_quo;

    function automatic logic [MAG_W-1:0] mag(input logic signed [DIFF_W-1:0] v);
        logic [DIFF_W-1:0] t;
        t = v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
        return t[MAG_W-1:0];
    endfunction

    function automatic logic signed [DIFF_W-1:0] dif(input logic signed [COORD_W-1:0] a,
                                                     input logic signed [COORD_W-1:0] b);
        return DIFF_W'(a) - DIFF_W'(b);
    endfunction

    function automatic logic in_unit(input logic signed [DET_W-1:0] n,
                                     input logic signed [DET_W-1:0] d);
        if (d < 0) begin
            return (n <= 0) && (n >= d);
        end
        return (n >= 0) && (n <= d);
    endfunction

    function automatic logic signed [COORD_W-1:0] smin(input logic signed [COORD_W-1:0] a,
                                                       input logic signed [COORD_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic signed [COORD_W-1:0] smax(input logic signed [COORD_W-1:0] a,
                                                       input logic signed [COORD_W-1:0] b);
        return (a > b) ? a : b;
    endfunction

    assign o_ready    = (r_state == S_IDLE);
    assign take       = o_ready && i_valid;
    assign we_path    = take && i_word.op == OP_PATH && r_pc < PCW'(MAX_PATH_POINTS);
    assign we_curve   = take && i_word.op == OP_CURVE && r_cc < CCW'(MAX_CURVE_POINTS);
    assign o_valid    = r_out_valid;
    assign o_stop_x   = r_out_stop;
    assign o_found    = r_out_found;
    assign o_overflow = r_out_ovf;

    always_comb begin
        path_addr  = r_i;
        curve_addr = '0;
        unique case (r_state)
            S_LD_B:  begin
                path_addr  = r_i + 1'b1;
                curve_addr = CAW'(1);
            end
            S_NXT_J: curve_addr = r_j + 1'b1;
            default: curve_addr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we_path) begin
            path_x[r_pc[PAW-1:0]] <= i_word.x;
            path_y[r_pc[PAW-1:0]] <= i_word.y;
        end
        if (we_curve) begin
            curve_x[r_cc[CAW-1:0]] <= i_word.x;
            curve_y[r_cc[CAW-1:0]] <= i_word.y;
        end
        r_px <= path_x[path_addr];
        r_py <= path_y[path_addr];
        r_cx <= curve_x[curve_addr];
        r_cy <= curve_y[curve_addr];
    end

    always_comb begin
        da = dif(r_x4, r_x2);
        db = dif(r_y4, r_y3);
        dc = dif(r_x4, r_x3);
        dd = dif(r_y4, r_y2);
        de = dif(r_x1, r_x2);
        df = dif(r_y1, r_y2);
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        mul_s = 1'b0;
        if (r_state == S_NUM) begin
            mul_a = r_k[0] ? r_pm[2*MAG_W-1:MAG_W] : r_pm[MAG_W-1:0];
            mul_b = r_me;
        end else begin
            case (r_k)
                3'd0: begin mul_a = r_ma; mul_b = r_mb; mul_s = r_sa ^ r_sb; end
                3'd1: begin mul_a = r_mc; mul_b = r_md; mul_s = r_sc ^ r_sd; end
                3'd2: begin mul_a = r_me; mul_b = r_mb; mul_s = r_se ^ r_sb; end
                3'd3: begin mul_a = r_mc; mul_b = r_mf; mul_s = r_sc ^ r_sf; end
                3'd4: begin mul_a = r_me; mul_b = r_md; mul_s = r_se ^ r_sd; end
                3'd5: begin mul_a = r_ma; mul_b = r_mf; mul_s = r_sa ^ r_sf; end
                default: begin mul_a = '0; mul_b = '0; mul_s = 1'b0; end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        r_psg  <= mul_s;
    end

    assign term = r_psg ? DET_W'(0) - DET_W'(r_prod) : DET_W'(r_prod);

    always_comb begin
        p_abs         = r_p[DET_W-1] ? DET_W'(-r_p) : DET_W'(r_p);
        d_abs         = r_d[DET_W-1] ? DET_W'(-r_d) : DET_W'(r_d);
        d_zero        = (r_d == '0);
        p_zero        = (r_p == '0);
        q_zero        = (r_q == '0);
        proper        = !d_zero && in_unit(r_p, r_d) && in_unit(r_q, r_d);
        collinear_hit = d_zero && p_zero && q_zero &&
                        (smin(smax(r_y1, r_y2), smax(r_y3, r_y4)) >=
                         smax(smin(r_y1, r_y2), smin(r_y3, r_y4)));
        col_x         = smax(smin(r_x1, r_x2), smin(r_x3, r_x4));
        more_j        = ((CCW+1)'(r_j) + (CCW+1)'(2)) < (CCW+1)'(r_cc);
        more_i        = ((PCW+1)'(r_i) + (PCW+1)'(2)) < (PCW+1)'(r_pc);
    end

    pfcx_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_num),
        .i_den   (r_dm),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_LD_B: begin
                r_x1 <= r_px;
                r_y1 <= r_py;
                r_x3 <= r_cx;
                r_y3 <= r_cy;
            end
            S_LD_C: begin
                r_x2 <= r_px;
                r_y2 <= r_py;
                r_x4 <= r_cx;
                r_y4 <= r_cy;
            end
            S_LD_J: begin
                r_x3 <= r_x4;
                r_y3 <= r_y4;
                r_x4 <= r_cx;
                r_y4 <= r_cy;
            end
            S_DIF: begin
                r_ma <= mag(da); r_sa <= da[DIFF_W-1];
                r_mb <= mag(db); r_sb <= db[DIFF_W-1];
                r_mc <= mag(dc); r_sc <= dc[DIFF_W-1];
                r_md <= mag(dd); r_sd <= dd[DIFF_W-1];
                r_me <= mag(de); r_se <= de[DIFF_W-1];
                r_mf <= mag(df); r_sf <= df[DIFF_W-1];
            end
            S_MUL: begin
                case (r_k)
                    3'd1: r_p <= term;
                    3'd2: r_p <= r_p - term;
                    3'd3: r_d <= term;
                    3'd4: r_d <= r_d - term;
                    3'd5: r_q <= term;
                    3'd6: r_q <= r_q - term;
                    default: r_p <= r_p;
                endcase
            end
            S_EVAL: begin
                r_pm  <= p_abs[PROD_W-1:0];
                r_dm  <= d_abs;
                r_neg <= r_p[DET_W-1] ^ r_d[DET_W-1] ^ r_se;
                r_num <= p_abs[DET_W-2] ? (NUM_W'(r_me) << (2 * MAG_W)) : '0;
            end
            S_NUM: begin
                case (r_k)
                    3'd1: r_num <= r_num + NUM_W'(r_prod);
                    3'd2: r_num <= r_num + (NUM_W'(r_prod) << MAG_W);
                    default: r_num <= r_num;
                endcase
            end
            default: r_num <= r_num;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE) begin
            r_out_stop  <= r_stop;
            r_out_found <= r_found;
            r_out_ovf   <= r_drop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pc        <= '0;
            r_cc        <= '0;
            r_drop      <= 1'b0;
            r_i         <= '0;
            r_j         <= '0;
            r_k         <= '0;
            r_found     <= 1'b0;
            r_stop      <= ONE;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= 1'b0;
            r_div_start <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (take) begin
                        case (i_word.op)
                            OP_PATH: begin
                                if (we_path) r_pc <= r_pc + 1'b1;
                                else r_drop <= 1'b1;
                            end
                            OP_CURVE: begin
                                if (we_curve) r_cc <= r_cc + 1'b1;
                                else r_drop <= 1'b1;
                            end
                            default: begin
                                r_i <= '0;
                                r_j <= '0;
                                if (r_pc < PCW'(2) || r_cc < CCW'(2)) begin
                                    r_found <= 1'b0;
                                    r_stop  <= ONE;
                                    r_state <= S_DONE;
                                end else begin
                                    r_state <= S_LD_A;
                                end
                            end
                        endcase
                    end
                end
                S_LD_A:  r_state <= S_LD_B;
                S_LD_B:  r_state <= S_LD_C;
                S_LD_C:  r_state <= S_DIF;
                S_NXT_J: r_state <= S_LD_J;
                S_LD_J:  r_state <= S_DIF;
                S_DIF: begin
                    r_k     <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_k <= r_k + 1'b1;
                    if (r_k == 3'd6) r_state <= S_EVAL;
                end
                S_EVAL: begin
                    r_k <= '0;
                    if (proper) begin
                        r_state <= S_NUM;
                    end else if (collinear_hit) begin
                        r_found <= 1'b1;
                        r_stop  <= col_x;
                        r_state <= S_DONE;
                    end else if (more_j) begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_NXT_J;
                    end else if (more_i) begin
                        r_i     <= r_i + 1'b1;
                        r_j     <= '0;
                        r_state <= S_LD_A;
                    end else begin
                        r_found <= 1'b0;
                        r_stop  <= ONE;
                        r_state <= S_DONE;
                    end
                end
                S_NUM: begin
                    r_k <= r_k + 1'b1;
                    if (r_k == 3'd2) begin
                        r_div_start <= 1'b1;
                        r_state     <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_found <= 1'b1;
                        r_stop  <= r_neg ? r_x2 - div_quo : r_x2 + div_quo;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    r_out_valid <= 1'b1;
                    r_pc        <= '0;
                    r_cc        <= '0;
                    r_drop      <= 1'b0;
                    r_state     <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |=> !r_out_valid)
        else $error("result held for more than one cycle");
    a_div_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) && div_done |=> (r_state == S_DONE))
        else $error("quotient not turned into a result");
    a_result_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |=> (r_pc == '0) && (r_cc == '0) && !r_drop)
        else $error("lists not cleared after compute");
`endif

endmodule

`default_nettype wire

[tb/sv/tb_polyline_first_crossing_x.sv]
// tb_polyline_first_crossing_x: self-checking bench for polyline_first_crossing_x.
// Depends on pfcx_pkg and the block RTL; loads polylines, some past the store limits, runs
// compute words and checks each result strobe against a predictor of the crossing search.
`default_nettype none

class crossing_scoreboard;
    typedef logic signed [127:0] t_wide;

    int path_xs[$], path_ys[$], curve_xs[$], curve_ys[$];
    bit dropped;
    logic [31:0] exp_stop[$];
    bit exp_found[$], exp_ovf[$];
    int errors;

    function void clear_lists();
        path_xs.delete(); path_ys.delete(); curve_xs.delete(); curve_ys.delete();
    endfunction

    function bit in_unit(t_wide n, t_wide d);
        if (d < 0) return n <= 0 && n >= d;
        return n >= 0 && n <= d;
    endfunction

    function longint mn(longint a, longint b);
        return a < b ? a : b;
    endfunction

    function longint mx(longint a, longint b);
        return a > b ? a : b;
    endfunction

    function bit find_crossing(output longint hit);
        longint x1, y1, x2, y2, x3, y3, x4, y4, dx, step;
        t_wide p, d, q, num, quo;
        bit neg;
        hit = 0;
        if (path_xs.size() < 2 || curve_xs.size() < 2) return 0;
        for (int i = 0; i + 1 < path_xs.size(); i++) begin
            x1 = path_xs[i]; y1 = path_ys[i]; x2 = path_xs[i+1]; y2 = path_ys[i+1];
            for (int j = 0; j + 1 < curve_xs.size(); j++) begin
                x3 = curve_xs[j]; y3 = curve_ys[j]; x4 = curve_xs[j+1]; y4 = curve_ys[j+1];
                p = t_wide'(x4 - x2) * t_wide'(y4 - y3) - t_wide'(x4 - x3) * t_wide'(y4 - y2);
                d = t_wide'(x1 - x2) * t_wide'(y4 - y3) - t_wide'(x4 - x3) * t_wide'(y1 - y2);
                q = t_wide'(x1 - x2) * t_wide'(y4 - y2) - t_wide'(x4 - x2) * t_wide'(y1 - y2);
                if (d != 0) begin
                    if (!in_unit(p, d) || !in_unit(q, d)) continue;
                    dx = x1 - x2;
                    num = (p < 0 ? -p : p) * t_wide'(dx < 0 ? -dx : dx);
                    quo = num / (d < 0 ? -d : d);
                    neg = ((p < 0) != (d < 0)) != (dx < 0);
                    step = longint'({32'd0, quo[31:0]});
                    hit = x2 + (neg ? -step : step);
                    return 1;
                end
                if (p != 0 || q != 0) continue;
                if (mn(mx(y1, y2), mx(y3, y4)) >= mx(mn(y1, y2), mn(y3, y4))) begin
                    hit = mx(mn(x1, x2), mn(x3, x4));
                    return 1;
                end
            end
        end
        return 0;
    endfunction

    function void note_word(logic [1:0] cmd, logic [31:0] x, logic [31:0] y);
        longint hit;
        bit f;
        case (cmd)
            pfcx_pkg::OP_PATH: begin
                if (path_xs.size() < 256) begin
                    path_xs.insert(path_xs.size(), int'(x));
                    path_ys.insert(path_ys.size(), int'(y));
                end else
                    dropped = 1;
            end
            pfcx_pkg::OP_CURVE: begin
                if (curve_xs.size() < 256) begin
                    curve_xs.insert(curve_xs.size(), int'(x));
                    curve_ys.insert(curve_ys.size(), int'(y));
                end else
                    dropped = 1;
            end
            pfcx_pkg::OP_COMPUTE: begin
                f = find_crossing(hit);
                exp_stop.insert(exp_stop.size(), f ? hit[31:0] : 32'h0001_0000);
                exp_found.insert(exp_found.size(), f);
                exp_ovf.insert(exp_ovf.size(), dropped);
                clear_lists();
                dropped = 0;
            end
            default: ;
        endcase
    endfunction

    function void check_result(logic [31:0] stop, logic found, logic ovf);
        logic [31:0] es;
        bit ef, eo;
        if (exp_stop.size() == 0) begin
            $display("%0t: unexpected result stop_x=%h found=%b overflow=%b",
                     $time, stop, found, ovf);
            errors++;
            return;
        end
        es = exp_stop.pop_front(); ef = exp_found.pop_front(); eo = exp_ovf.pop_front();
        if (stop !== es) begin
            $display("%0t: stop_x expected %h actual %h", $time, es, stop); errors++;
        end
        if (found !== ef) begin
            $display("%0t: found expected %b actual %b", $time, ef, found); errors++;
        end
        if (ovf !== eo) begin
            $display("%0t: overflow expected %b actual %b", $time, eo, ovf); errors++;
        end
    endfunction
endclass

module tb_polyline_first_crossing_x
    import pfcx_pkg::*;
();

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int ONE = 32'h0001_0000;
    localparam int LIMIT_CYCLES = 3_000_000;

    logic i_clk = 0, i_rst_n = 0, start = 0;
    logic [1:0] i_command = OP_PATH;
    logic signed [31:0] i_coord_x = 0, i_coord_y = 0;
    logic busy, o_valid, o_found, o_overflow;
    logic signed [31:0] o_stop_x;

    crossing_scoreboard sb = new();
    int send_idle_pct = 0;
    int cycles = 0;

    polyline_first_crossing_x dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_command(i_command), .i_coord_x(i_coord_x), .i_coord_y(i_coord_y),
        .o_valid(o_valid), .o_stop_x(o_stop_x), .o_found(o_found), .o_overflow(o_overflow)
    );

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("FAIL polyline_first_crossing_x");
            $finish;
        end
        if (i_rst_n && start && !busy) sb.note_word(i_command, i_coord_x, i_coord_y);
        if (i_rst_n && o_valid) sb.check_result(o_stop_x, o_found, o_overflow);
    end

    task automatic send_word(logic [1:0] cmd, int x, int y);
        bit ok;
        while ($urandom_range(99) < send_idle_pct) begin
            start <= 0;
            @(posedge i_clk);
        end
        start <= 1; i_command <= cmd; i_coord_x <= x; i_coord_y <= y;
        do begin
            @(negedge i_clk);
            ok = !busy;
            @(posedge i_clk);
        end while (!ok);
    endtask

    task automatic add_path(int x, int y);
        send_word(OP_PATH, x, y);
    endtask

    task automatic add_curve(int x, int y);
        send_word(OP_CURVE, x, y);
    endtask

    task automatic compute();
        send_word(OP_COMPUTE, $urandom, $urandom);
    endtask

    function automatic int rand_coord();
        case ($urandom_range(9))
            0, 1: return $urandom;
            2: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
            3: return int'($urandom_range(0, 6000)) - 3000;
            default: return (int'($urandom_range(0, 8)) - 4) * ONE;
        endcase
    endfunction

    task automatic random_set();
        int np, nc;
        np = $urandom_range(0, 5);
        nc = $urandom_range(0, 5);
        while (np + nc > 0) begin
            if ($urandom_range(14) == 0) send_word(CMD_UNUSED, $urandom, $urandom);
            if (nc == 0 || (np > 0 && $urandom_range(1))) begin
                add_path(rand_coord(), rand_coord()); np--;
            end else begin
                add_curve(rand_coord(), rand_coord()); nc--;
            end
        end
        compute();
    endtask

    task automatic random_phase(int words);
        for (int n = 0; n < words; n += 6) random_set();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        compute();
        add_path(0, 0); add_curve(ONE, ONE); compute();
        add_path(-ONE, 0); add_path(ONE, 0); add_curve(0, -ONE); add_curve(0, ONE);
        compute();
        add_path(0, 0); add_path(4*ONE, 0); add_curve(0, ONE); add_curve(4*ONE, ONE);
        compute();
        add_path(0, 0); add_path(4*ONE, 4*ONE); add_curve(2*ONE, 2*ONE);
        add_curve(6*ONE, 6*ONE); compute();
        add_path(0, 0); add_path(4*ONE, 4*ONE); add_curve(5*ONE, 5*ONE);
        add_curve(6*ONE, 6*ONE); send_word(CMD_UNUSED, -1, -1); compute();
        add_path(32'h8000_0000, 32'h8000_0000); add_path(32'h7fff_ffff, 32'h7fff_ffff);
        add_curve(32'h8000_0000, 32'h7fff_ffff); add_curve(32'h7fff_ffff, 32'h8000_0000);
        compute();
        for (int k = 0; k < 257; k++) add_path(k * ONE, k[0] ? ONE : -ONE);
        add_curve(300 * ONE, 0); add_curve(301 * ONE, ONE); compute();
        for (int k = 0; k < 258; k++) add_curve(-k * 3, k * 7);
        add_path(ONE, 0); add_path(2*ONE, 0); compute();

        send_idle_pct = 22; random_phase(84);
        send_idle_pct = 79; random_phase(84);
        send_idle_pct = 0;  random_phase(84);
        start <= 0;

        while (sb.exp_stop.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (sb.errors == 0)
            $display("PASS polyline_first_crossing_x");
        else
            $display("FAIL polyline_first_crossing_x");
        $finish;
    end
endmodule

`default_nettype wire
